@@ rtl/core/srb_pkg.sv @@
// Shared types, constants and helper functions for the serial tx/rx byte rings.
// No dependencies; used by srb_ctrl and serial_tx_rx_ring_buffers.
package srb_pkg;

  localparam int unsigned TX_DEPTH = 64;
  localparam int unsigned RX_DEPTH = 64;
  localparam int unsigned TX_AW    = $clog2(TX_DEPTH);
  localparam int unsigned RX_AW    = $clog2(RX_DEPTH);

  localparam logic [7:0] NO_BYTE    = 8'hFF;
  localparam int unsigned CNT_MAX   = 63;

  typedef enum logic [1:0] {
    FUNC_TX_PUSH  = 2'd0,
    FUNC_TX_READY = 2'd1,
    FUNC_RX_BYTE  = 2'd2,
    FUNC_RX_READ  = 2'd3
  } srb_func_e;

  typedef struct packed {
    srb_func_e  func;
    logic [7:0] data_in;
  } srb_in_t;

  typedef struct packed {
    logic [7:0] data_out;
    logic       data_valid;
    logic       push_rejected;
    logic       wake_event;
    logic       tx_request;
    logic [5:0] rx_count;
  } srb_out_t;

  // Per-word result from the ring control, minus the byte read from a store.
  typedef struct packed {
    logic       rd_rx;
    logic       data_valid;
    logic       push_rejected;
    logic       wake_event;
    logic       tx_request;
    logic [5:0] rx_count;
  } srb_ctrl_res_t;

  typedef struct packed {
    logic             we;
    logic [TX_AW-1:0] waddr;
    logic [7:0]       wdata;
    logic             re;
    logic [TX_AW-1:0] raddr;
  } srb_tx_req_t;

  typedef struct packed {
    logic             we;
    logic [RX_AW-1:0] waddr;
    logic [7:0]       wdata;
    logic             re;
    logic [RX_AW-1:0] raddr;
  } srb_rx_req_t;

  function automatic logic [TX_AW-1:0] tx_next(input logic [TX_AW-1:0] p);
    return (p == TX_AW'(TX_DEPTH - 1)) ? '0 : p + TX_AW'(1);
  endfunction

  function automatic logic [RX_AW-1:0] rx_next(input logic [RX_AW-1:0] p);
    return (p == RX_AW'(RX_DEPTH - 1)) ? '0 : p + RX_AW'(1);
  endfunction

  // Bytes held in the rx ring, saturated to the 6-bit count field.
  function automatic logic [5:0] rx_level(input logic [RX_AW-1:0] head,
                                          input logic [RX_AW-1:0] tail);
    logic [RX_AW:0] sum;
    logic [RX_AW-1:0] lvl;
    logic [31:0] wide;
    sum  = {1'b0, head} + (RX_AW+1)'(RX_DEPTH) - {1'b0, tail};
    lvl  = (head >= tail) ? (head - tail) : sum[RX_AW-1:0];
    wide = 32'(lvl);
    return (wide > 32'(CNT_MAX)) ? 6'(CNT_MAX) : wide[5:0];
  endfunction

endpackage

@@ rtl/core/srb_ram.sv @@
// Generic single-write, single-read byte store with registered read data.
// No dependencies.
module srb_ram #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned WIDTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read data holds between reads
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/srb_ctrl.sv @@
// Pointer and flag control for the tx and rx rings; drives the store ports.
// Depends on srb_pkg.
module srb_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  acc_i,
  input  srb_pkg::srb_in_t      item_i,
  output srb_pkg::srb_tx_req_t  tx_req_o,
  output srb_pkg::srb_rx_req_t  rx_req_o,
  output srb_pkg::srb_ctrl_res_t res_o
);

  logic [srb_pkg::TX_AW-1:0] tx_head_q, tx_head_d, tx_tail_q, tx_tail_d;
  logic [srb_pkg::RX_AW-1:0] rx_head_q, rx_head_d, rx_tail_q, rx_tail_d;
  logic                      tx_req_q, tx_req_d, tx_full_q, tx_full_d;
  logic [srb_pkg::TX_AW-1:0] tx_head_nx, tx_tail_nx;
  logic [srb_pkg::RX_AW-1:0] rx_head_nx, rx_tail_nx;

  assign tx_head_nx = srb_pkg::tx_next(tx_head_q);
  assign tx_tail_nx = srb_pkg::tx_next(tx_tail_q);
  assign rx_head_nx = srb_pkg::rx_next(rx_head_q);
  assign rx_tail_nx = srb_pkg::rx_next(rx_tail_q);

  always_comb begin
    tx_head_d = tx_head_q;
    tx_tail_d = tx_tail_q;
    rx_head_d = rx_head_q;
    rx_tail_d = rx_tail_q;
    tx_req_d  = tx_req_q;
    tx_full_d = tx_full_q;

    tx_req_o.we    = 1'b0;
    tx_req_o.waddr = tx_head_q;
    tx_req_o.wdata = item_i.data_in;
    tx_req_o.re    = 1'b0;
    tx_req_o.raddr = tx_tail_q;
    rx_req_o.we    = 1'b0;
    rx_req_o.waddr = rx_head_q;
    rx_req_o.wdata = item_i.data_in;
    rx_req_o.re    = 1'b0;
    rx_req_o.raddr = rx_tail_q;

    res_o.rd_rx         = 1'b0;
    res_o.data_valid    = 1'b0;
    res_o.push_rejected = 1'b0;
    res_o.wake_event    = 1'b0;

    case (item_i.func)
      srb_pkg::FUNC_TX_PUSH: begin
        if (tx_head_nx == tx_tail_q) begin
          res_o.push_rejected = 1'b1;
          tx_full_d           = 1'b1;
        end else begin
          tx_req_o.we = acc_i;
          tx_head_d   = tx_head_nx;
          tx_req_d    = 1'b1;
        end
      end
      srb_pkg::FUNC_TX_READY: begin
        if (tx_head_q != tx_tail_q) begin
          res_o.data_valid = 1'b1;
          tx_req_o.re      = acc_i;
          tx_tail_d        = tx_tail_nx;
          if (tx_tail_nx == tx_head_q) begin
            tx_req_d = 1'b0;
          end
          if (tx_full_q) begin
            tx_full_d        = 1'b0;
            res_o.wake_event = 1'b1;
          end
        end
      end
      srb_pkg::FUNC_RX_BYTE: begin
        rx_req_o.we = acc_i;
        rx_head_d   = rx_head_nx;
        // full ring: drop the oldest byte
        if (rx_head_nx == rx_tail_q) begin
          rx_tail_d = rx_tail_nx;
        end
      end
      srb_pkg::FUNC_RX_READ: begin
        res_o.rd_rx = 1'b1;
        if (rx_head_q != rx_tail_q) begin
          res_o.data_valid = 1'b1;
          rx_req_o.re      = acc_i;
          rx_tail_d        = rx_tail_nx;
        end
      end
      default: begin
        res_o.rd_rx = 1'b0;
      end
    endcase

    res_o.tx_request = tx_req_d;
    res_o.rx_count   = srb_pkg::rx_level(rx_head_d, rx_tail_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tx_head_q <= '0;
      tx_tail_q <= '0;
      rx_head_q <= '0;
      rx_tail_q <= '0;
      tx_req_q  <= 1'b0;
      tx_full_q <= 1'b0;
    end else if (acc_i) begin
      tx_head_q <= tx_head_d;
      tx_tail_q <= tx_tail_d;
      rx_head_q <= rx_head_d;
      rx_tail_q <= rx_tail_d;
      tx_req_q  <= tx_req_d;
      tx_full_q <= tx_full_d;
    end
  end

`ifndef SYNTHESIS
  // request enable tracks a non-empty tx ring exactly
  a_req_matches_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tx_req_q == (tx_head_q != tx_tail_q))
    else $error("tx request out of step with tx ring level");

  a_full_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tx_full_q |-> (tx_head_q != tx_tail_q))
    else $error("full flag set on empty tx ring");

  a_no_rw_same_ring: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(tx_req_o.we && tx_req_o.re) && !(rx_req_o.we && rx_req_o.re))
    else $error("store written and read by the same word");
`endif

endmodule

@@ rtl/core/serial_tx_rx_ring_buffers.sv @@
// A word accepted into the read stage moves on to the output register when it is free,
// and out_valid_o then shows its result. Throughput: one word per cycle while
// in_stall_o is low; the store read port registers data in the first stage.
// in_stall_o rises only when both the read stage and the output register are held.
// Reset clears ring pointers, flags and stage valids at once; store contents stay
// undefined until written, so there is no clearing pass.
module serial_tx_rx_ring_buffers (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  srb_pkg::srb_in_t  in_item_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output srb_pkg::srb_out_t out_item_o
);

  srb_pkg::srb_tx_req_t   tx_req;
  srb_pkg::srb_rx_req_t   rx_req;
  srb_pkg::srb_ctrl_res_t ctrl_res;
  logic [7:0]             tx_rdata, rx_rdata;

  logic                   acc;
  logic                   s1_valid_q, s1_valid_d;
  srb_pkg::srb_ctrl_res_t s1_res_q;
  logic                   out_valid_q, out_valid_d;
  srb_pkg::srb_out_t      out_item_q, out_item_d;
  logic                   out_free, s1_move, s1_free;

  srb_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .acc_i    (acc),
    .item_i   (in_item_i),
    .tx_req_o (tx_req),
    .rx_req_o (rx_req),
    .res_o    (ctrl_res)
  );

  srb_ram #(.DEPTH(srb_pkg::TX_DEPTH), .WIDTH(8)) u_tx_ram (
    .clk_i   (clk_i),
    .we_i    (tx_req.we),
    .waddr_i (tx_req.waddr),
    .wdata_i (tx_req.wdata),
    .re_i    (tx_req.re),
    .raddr_i (tx_req.raddr),
    .rdata_o (tx_rdata)
  );

  srb_ram #(.DEPTH(srb_pkg::RX_DEPTH), .WIDTH(8)) u_rx_ram (
    .clk_i   (clk_i),
    .we_i    (rx_req.we),
    .waddr_i (rx_req.waddr),
    .wdata_i (rx_req.wdata),
    .re_i    (rx_req.re),
    .raddr_i (rx_req.raddr),
    .rdata_o (rx_rdata)
  );

  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_move    = s1_valid_q && out_free;
  assign s1_free    = !s1_valid_q || s1_move;
  assign in_stall_o = !s1_free;
  assign acc        = in_valid_i && s1_free;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (acc) begin
      s1_valid_d = 1'b1;
    end else if (s1_move) begin
      s1_valid_d = 1'b0;
    end

    out_valid_d = out_valid_q;
    if (s1_move) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end

    out_item_d               = out_item_q;
    out_item_d.data_valid    = s1_res_q.data_valid;
    out_item_d.push_rejected = s1_res_q.push_rejected;
    out_item_d.wake_event    = s1_res_q.wake_event;
    out_item_d.tx_request    = s1_res_q.tx_request;
    out_item_d.rx_count      = s1_res_q.rx_count;
    if (!s1_res_q.data_valid) begin
      out_item_d.data_out = srb_pkg::NO_BYTE;
    end else if (s1_res_q.rd_rx) begin
      out_item_d.data_out = rx_rdata;
    end else begin
      out_item_d.data_out = tx_rdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      s1_res_q <= ctrl_res;
    end
    if (s1_move) begin
      out_item_q <= out_item_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

`ifndef SYNTHESIS
  a_stall_when_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid_q && out_valid_q && out_stall_i))
    else $error("input stalled with room in the pipeline");

  a_no_byte_marker: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_item_o.data_valid) |-> (out_item_o.data_out == srb_pkg::NO_BYTE))
    else $error("invalid result word carries a byte");

  a_reject_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.push_rejected) |->
      (!out_item_o.data_valid && !out_item_o.wake_event))
    else $error("rejected push reports a pop");

  a_stage_advances: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_move |=> out_valid_o)
    else $error("read stage word lost on the way out");
`endif

endmodule
